### sv/svpwm_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// svpwm_pkg: shared types and constants for the SVPWM timing block
// Fixed-point widths, the sector code type, queue beat and result layouts.
// ---------------------------------------------------------------------------
package svpwm_pkg;

  // field widths
  localparam int VW  = 16;   // voltage fields, Q8.8
  localparam int PW  = 16;   // effective period bits
  localparam int SEW = 3;    // sector number

  // numerator path
  localparam int NW   = 35;  // signed numerators K*v
  localparam int AW   = 34;  // magnitude of a numerator
  localparam int MAGW = 42;  // |P*num| / 256

  // dwell path
  localparam int TW  = 34;   // signed dwell terms in Q8 ticks
  localparam int SW  = 35;   // signed Tx + Ty
  localparam int PRW = PW + TW;  // P * |T|
  localparam int WW  = 38;   // signed compare arithmetic

  // pipelined divider: dividend < divisor * 2^DIV_QW is required
  localparam int DIV_NW = 58;
  localparam int DIV_DW = 35;
  localparam int DIV_QW = 34;

  // queue between front and back
  localparam int QDEPTH = 8;
  localparam int QAW    = 3;
  localparam int QCW    = 4;

  localparam logic [PW-1:0] PERIOD_RST = PW'(16800);
  localparam logic [VW-1:0] BUS_MIN    = VW'(256);   // 1.0 V in Q8.8

  // Q16 constants
  localparam logic signed [NW-1:0] K_SQRT3      = NW'(113512);
  localparam logic signed [NW-1:0] K_HALF_SQRT3 = NW'(56756);
  localparam logic signed [NW-1:0] K_THREE_HALF = NW'(98304);

  // sector code N = 4C + 2B + A
  typedef enum logic [2:0] {
    SC_NONE_LO = 3'd0,
    SC_N1      = 3'd1,
    SC_N2      = 3'd2,
    SC_N3      = 3'd3,
    SC_N4      = 3'd4,
    SC_N5      = 3'd5,
    SC_N6      = 3'd6,
    SC_NONE_HI = 3'd7
  } sect_code_t;

  // one queue beat: divider operands and what travels with them
  typedef struct packed {
    logic [MAGW-1:0] mag_x;
    logic [MAGW-1:0] mag_y;
    logic [MAGW-1:0] mag_z;
    logic            neg_x;
    logic            neg_y;
    logic            neg_z;
    logic [VW-1:0]   bus;
    logic [PW-1:0]   per;
    sect_code_t      code;
    logic            uv;
  } q_entry_t;

  typedef struct packed {
    logic [QCW-1:0] level;
  } q_stat_t;

  typedef struct packed {
    logic            vld;
    logic [PW-1:0]   cmp_a;
    logic [PW-1:0]   cmp_b;
    logic [PW-1:0]   cmp_c;
    logic [SEW-1:0]  sector;
    logic            uv;
    logic            ovm;
  } res_t;

  function automatic logic [SEW-1:0] sector_num(input sect_code_t c);
    logic [SEW-1:0] s;
    case (c)
      SC_N1:   s = SEW'(2);
      SC_N2:   s = SEW'(6);
      SC_N3:   s = SEW'(1);
      SC_N4:   s = SEW'(4);
      SC_N5:   s = SEW'(3);
      SC_N6:   s = SEW'(5);
      default: s = SEW'(0);
    endcase
    return s;
  endfunction

endpackage

### sv/svpwm_div.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// svpwm_div: pipelined restoring divider
// One quotient bit per stage, a new operand pair every cycle.
// ---------------------------------------------------------------------------
module svpwm_div (
  input  logic                           clk,
  input  logic [svpwm_pkg::DIV_NW-1:0]   dividend,
  input  logic [svpwm_pkg::DIV_DW-1:0]   divisor,
  output logic [svpwm_pkg::DIV_QW-1:0]   quotient
);
  import svpwm_pkg::*;

  logic [DIV_DW-1:0] rem_r [DIV_QW];
  logic [DIV_DW-1:0] dvs_r [DIV_QW];
  logic [DIV_QW-1:0] low_r [DIV_QW];
  logic [DIV_QW-1:0] quo_r [DIV_QW];

  logic [DIV_DW-1:0] rem_nxt [DIV_QW];
  logic [DIV_DW-1:0] dvs_nxt [DIV_QW];
  logic [DIV_QW-1:0] low_nxt [DIV_QW];
  logic [DIV_QW-1:0] quo_nxt [DIV_QW];

  always_comb begin
    logic [DIV_DW-1:0] rem_i;
    logic [DIV_DW-1:0] dvs_i;
    logic [DIV_QW-1:0] low_i;
    logic [DIV_QW-1:0] quo_i;
    logic [DIV_DW:0]   trial;
    logic [DIV_DW:0]   diff;
    logic              ge;
    for (int s = 0; s < DIV_QW; s++) begin
      if (s == 0) begin
        // top bits are already below the divisor by the range contract
        rem_i = DIV_DW'(dividend[DIV_NW-1:DIV_QW]);
        dvs_i = divisor;
        low_i = dividend[DIV_QW-1:0];
        quo_i = '0;
      end else begin
        rem_i = rem_r[s-1];
        dvs_i = dvs_r[s-1];
        low_i = low_r[s-1];
        quo_i = quo_r[s-1];
      end
      trial = {rem_i, low_i[DIV_QW-1]};
      diff  = trial - {1'b0, dvs_i};
      ge    = (trial >= {1'b0, dvs_i});
      rem_nxt[s] = ge ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
      dvs_nxt[s] = dvs_i;
      low_nxt[s] = {low_i[DIV_QW-2:0], 1'b0};
      quo_nxt[s] = {quo_i[DIV_QW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < DIV_QW; s++) begin
      rem_r[s] <= rem_nxt[s];
      dvs_r[s] <= dvs_nxt[s];
      low_r[s] <= low_nxt[s];
      quo_r[s] <= quo_nxt[s];
    end
  end

  assign quotient = quo_r[DIV_QW-1];

endmodule

### sv/svpwm_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// svpwm_front: input stage of the SVPWM timing block
// Takes the vector beat, classifies the sector, forms |P*num|/256 per term.
// ---------------------------------------------------------------------------
module svpwm_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic signed [svpwm_pkg::VW-1:0] v_alpha,
  input  logic signed [svpwm_pkg::VW-1:0] v_beta,
  input  logic [svpwm_pkg::VW-1:0]    bus_voltage,
  input  logic [svpwm_pkg::PW-1:0]    period,
  input  svpwm_pkg::q_stat_t          q_stat,
  output logic                        push,
  output svpwm_pkg::q_entry_t         push_data
);
  import svpwm_pkg::*;

  logic accept;

  // stage 1: captured beat
  logic                 f1_vld_r;
  logic signed [VW-1:0] f1_va_r, f1_vb_r;
  logic [VW-1:0]        f1_bus_r;
  logic [PW-1:0]        f1_per_r;

  // stage 2: constant products
  logic                 f2_vld_r;
  logic signed [NW-1:0] f2_sqvb_r, f2_sqva_r, f2_hsvb_r, f2_thva_r;
  logic signed [VW-1:0] f2_vb_r;
  logic [VW-1:0]        f2_bus_r;
  logic [PW-1:0]        f2_per_r;
  logic                 f2_uv_r;

  // stage 3: numerators and sector code
  logic                 f3_vld_r;
  logic signed [NW-1:0] f3_nx_r, f3_ny_r, f3_nz_r;
  sect_code_t           f3_code_r;
  logic [VW-1:0]        f3_bus_r;
  logic [PW-1:0]        f3_per_r;
  logic                 f3_uv_r;

  // stage 4: magnitudes
  logic                 f4_vld_r;
  logic [AW-1:0]        f4_ax_r, f4_ay_r, f4_az_r;
  logic                 f4_nx_r, f4_ny_r, f4_nz_r;
  sect_code_t           f4_code_r;
  logic [VW-1:0]        f4_bus_r;
  logic [PW-1:0]        f4_per_r;
  logic                 f4_uv_r;

  logic [QCW:0]         used;
  logic signed [NW-1:0] vb_sh;
  logic                 bit_a, bit_b, bit_c;
  logic [PRW-1:0]       px, py, pz;

  // credit check: queue level plus everything still in flight here
  assign used = (QCW+1)'(q_stat.level) + (QCW+1)'(f1_vld_r) + (QCW+1)'(f2_vld_r)
              + (QCW+1)'(f3_vld_r) + (QCW+1)'(f4_vld_r);
  assign busy   = (used >= (QCW+1)'(QDEPTH));
  assign accept = start && !busy;

  assign vb_sh = NW'(f2_vb_r) <<< 16;
  assign bit_a = (f2_vb_r > 0);
  assign bit_b = (f2_sqva_r > vb_sh);
  assign bit_c = (-f2_sqva_r > vb_sh);

  assign px = PRW'(f4_per_r) * PRW'(f4_ax_r);
  assign py = PRW'(f4_per_r) * PRW'(f4_ay_r);
  assign pz = PRW'(f4_per_r) * PRW'(f4_az_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_vld_r <= 1'b0;
      f2_vld_r <= 1'b0;
      f3_vld_r <= 1'b0;
      f4_vld_r <= 1'b0;
    end else begin
      f1_vld_r <= accept;
      f2_vld_r <= f1_vld_r;
      f3_vld_r <= f2_vld_r;
      f4_vld_r <= f3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f1_va_r  <= v_alpha;
      f1_vb_r  <= v_beta;
      f1_bus_r <= bus_voltage;
      f1_per_r <= period;
    end

    f2_sqvb_r <= NW'(f1_vb_r) * K_SQRT3;
    f2_sqva_r <= NW'(f1_va_r) * K_SQRT3;
    f2_hsvb_r <= NW'(f1_vb_r) * K_HALF_SQRT3;
    f2_thva_r <= NW'(f1_va_r) * K_THREE_HALF;
    f2_vb_r   <= f1_vb_r;
    f2_bus_r  <= f1_bus_r;
    f2_per_r  <= f1_per_r;
    f2_uv_r   <= (f1_bus_r < BUS_MIN);

    f3_nx_r   <= f2_sqvb_r;
    f3_ny_r   <= f2_hsvb_r + f2_thva_r;
    f3_nz_r   <= f2_hsvb_r - f2_thva_r;
    f3_code_r <= sect_code_t'({bit_c, bit_b, bit_a});
    f3_bus_r  <= f2_bus_r;
    f3_per_r  <= f2_per_r;
    f3_uv_r   <= f2_uv_r;

    f4_nx_r   <= f3_nx_r[NW-1];
    f4_ny_r   <= f3_ny_r[NW-1];
    f4_nz_r   <= f3_nz_r[NW-1];
    f4_ax_r   <= AW'(f3_nx_r[NW-1] ? -f3_nx_r : f3_nx_r);
    f4_ay_r   <= AW'(f3_ny_r[NW-1] ? -f3_ny_r : f3_ny_r);
    f4_az_r   <= AW'(f3_nz_r[NW-1] ? -f3_nz_r : f3_nz_r);
    f4_code_r <= f3_code_r;
    f4_bus_r  <= f3_bus_r;
    f4_per_r  <= f3_per_r;
    f4_uv_r   <= f3_uv_r;
  end

  // products land in the queue storage; /256 of a magnitude is a shift
  always_comb begin
    push              = f4_vld_r;
    push_data.mag_x   = MAGW'(px[PRW-1:8]);
    push_data.mag_y   = MAGW'(py[PRW-1:8]);
    push_data.mag_z   = MAGW'(pz[PRW-1:8]);
    push_data.neg_x   = f4_nx_r;
    push_data.neg_y   = f4_ny_r;
    push_data.neg_z   = f4_nz_r;
    push_data.bus     = f4_bus_r;
    push_data.per     = f4_per_r;
    push_data.code    = f4_code_r;
    push_data.uv      = f4_uv_r;
  end

endmodule

### sv/svpwm_fifo.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// svpwm_fifo: short queue between front and back
// Drains one beat a cycle whenever not empty; read data is registered.
// ---------------------------------------------------------------------------
module svpwm_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  svpwm_pkg::q_entry_t  push_data,
  output svpwm_pkg::q_stat_t   q_stat,
  output logic                 rd_vld,
  output svpwm_pkg::q_entry_t  rd_data
);
  import svpwm_pkg::*;

  q_entry_t       mem [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCW-1:0] level_r, level_nxt;
  logic           pop;
  logic           rd_vld_r;
  q_entry_t       rd_data_r;

  assign pop = (level_r != '0);

  always_comb begin
    level_nxt = level_r;
    if (push && !pop) begin
      level_nxt = level_r + QCW'(1);
    end else if (pop && !push) begin
      level_nxt = level_r - QCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QAW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QAW'(1);
      end
      level_r  <= level_nxt;
      rd_vld_r <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
    if (pop) begin
      rd_data_r <= mem[rd_ptr_r];
    end
  end

  assign q_stat.level = level_r;
  assign rd_vld       = rd_vld_r;
  assign rd_data      = rd_data_r;

  // the front's credit count must keep the queue from overflowing
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && !pop && level_r == QCW'(QDEPTH)))
    else $error("svpwm_fifo: push into a full queue");

endmodule

### sv/svpwm_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// svpwm_back: dwell division, sector pick, rescale and compare generation
// Fully pipelined; one queue beat in and one result out per cycle.
// ---------------------------------------------------------------------------
module svpwm_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_vld,
  input  svpwm_pkg::q_entry_t  in_data,
  output svpwm_pkg::res_t      res
);
  import svpwm_pkg::*;

  typedef struct packed {
    logic       vld;
    logic       neg_x;
    logic       neg_y;
    logic       neg_z;
    logic [PW-1:0] per;
    sect_code_t code;
    logic       uv;
  } side1_t;

  typedef struct packed {
    logic                 vld;
    logic signed [TW-1:0] tx;
    logic signed [TW-1:0] ty;
    logic                 ntx;
    logic                 nty;
    logic                 ovm;
    logic [PW-1:0]        per;
    sect_code_t           code;
    logic                 uv;
  } side2_t;

  // ---- X/Y/Z division ----
  logic [DIV_QW-1:0] qx, qy, qz;
  side1_t            sd1_r [DIV_QW];
  side1_t            sd1_in;

  svpwm_div u_div_x (.clk, .dividend(DIV_NW'(in_data.mag_x)),
                     .divisor(DIV_DW'(in_data.bus)), .quotient(qx));
  svpwm_div u_div_y (.clk, .dividend(DIV_NW'(in_data.mag_y)),
                     .divisor(DIV_DW'(in_data.bus)), .quotient(qy));
  svpwm_div u_div_z (.clk, .dividend(DIV_NW'(in_data.mag_z)),
                     .divisor(DIV_DW'(in_data.bus)), .quotient(qz));

  always_comb begin
    sd1_in.vld   = in_vld;
    sd1_in.neg_x = in_data.neg_x;
    sd1_in.neg_y = in_data.neg_y;
    sd1_in.neg_z = in_data.neg_z;
    sd1_in.per   = in_data.per;
    sd1_in.code  = in_data.code;
    sd1_in.uv    = in_data.uv;
  end

  // ---- stage registers ----
  side1_t s1_r;
  logic signed [TW-1:0] s1_x_r, s1_y_r, s1_z_r;

  side1_t s2_r;
  logic signed [TW-1:0] s2_tx_r, s2_ty_r;

  side1_t s3_r;
  logic signed [TW-1:0] s3_tx_r, s3_ty_r;
  logic [TW-1:0]        s3_atx_r, s3_aty_r;
  logic [SW-1:0]        s3_sum_r;
  logic                 s3_ovm_r;

  side2_t         s4_r;
  logic [PRW-1:0] s4_px_r, s4_py_r;
  logic [SW-1:0]  s4_sum_r;

  logic [DIV_QW-1:0] rx, ry;
  side2_t            sd2_r [DIV_QW];

  side2_t               s6_r;
  logic signed [TW-1:0] s6_tx_r, s6_ty_r;

  side2_t               s7_r;
  logic signed [WW-1:0] s7_d_r, s7_hx_r, s7_hy_r;

  side2_t               s8_r;
  logic signed [WW-1:0] s8_ta_r, s8_tb_r, s8_hy_r;

  side2_t               s9_r;
  logic signed [WW-1:0] s9_ta_r, s9_tb_r, s9_tc_r;

  res_t res_r;

  // ---- combinational helpers ----
  logic signed [TW-1:0] x_c, y_c, z_c, tx_c, ty_c;
  logic signed [SW-1:0] sum_c, pq_c;
  logic signed [TW-1:0] rtx_c, rty_c;
  logic signed [WW-1:0] tx_w, ty_w, d_w, tx_adj, ty_adj, d_adj, ta_c;

  assign x_c = sd1_r[DIV_QW-1].neg_x ? -signed'(qx) : signed'(qx);
  assign y_c = sd1_r[DIV_QW-1].neg_y ? -signed'(qy) : signed'(qy);
  assign z_c = sd1_r[DIV_QW-1].neg_z ? -signed'(qz) : signed'(qz);

  always_comb begin
    case (s1_r.code)
      SC_N1:   begin tx_c = s1_z_r;  ty_c = s1_y_r;  end
      SC_N2:   begin tx_c = s1_y_r;  ty_c = -s1_x_r; end
      SC_N3:   begin tx_c = -s1_z_r; ty_c = s1_x_r;  end
      SC_N4:   begin tx_c = -s1_x_r; ty_c = s1_z_r;  end
      SC_N5:   begin tx_c = s1_x_r;  ty_c = -s1_y_r; end
      SC_N6:   begin tx_c = -s1_y_r; ty_c = -s1_z_r; end
      default: begin tx_c = '0;      ty_c = '0;      end
    endcase
  end

  assign sum_c = SW'(s2_tx_r) + SW'(s2_ty_r);
  assign pq_c  = SW'({s2_r.per, 8'b0});

  // rescaled term: P*256*|T| / sum, sign restored, truncated toward zero
  svpwm_div u_div_rx (.clk, .dividend({s4_px_r, 8'b0}),
                      .divisor(DIV_DW'(s4_sum_r)), .quotient(rx));
  svpwm_div u_div_ry (.clk, .dividend({s4_py_r, 8'b0}),
                      .divisor(DIV_DW'(s4_sum_r)), .quotient(ry));

  assign rtx_c = sd2_r[DIV_QW-1].ntx ? -signed'(rx) : signed'(rx);
  assign rty_c = sd2_r[DIV_QW-1].nty ? -signed'(ry) : signed'(ry);

  // signed halves and quarters round toward zero
  always_comb begin
    tx_w   = WW'(s6_tx_r);
    ty_w   = WW'(s6_ty_r);
    tx_adj = tx_w + signed'({{(WW-1){1'b0}}, tx_w[WW-1]});
    ty_adj = ty_w + signed'({{(WW-1){1'b0}}, ty_w[WW-1]});
    d_w    = s7_d_r;
    d_adj  = d_w + signed'({{(WW-2){1'b0}}, {2{d_w[WW-1]}}});
    ta_c   = d_adj >>> 2;
  end

  function automatic logic [PW-1:0] to_cmp(input logic signed [WW-1:0] q8,
                                           input logic [PW-1:0] per);
    logic [WW-9:0] v;
    logic [PW-1:0] c;
    v = q8[WW-1:8];
    if (q8[WW-1]) begin
      c = '0;
    end else if (v > (WW-8)'(per)) begin
      c = per;
    end else begin
      c = v[PW-1:0];
    end
    return c;
  endfunction

  logic signed [WW-1:0] ca_c, cb_c, cc_c;

  always_comb begin
    case (s9_r.code)
      SC_N1:   begin ca_c = s9_tb_r; cb_c = s9_ta_r; cc_c = s9_tc_r; end
      SC_N2:   begin ca_c = s9_ta_r; cb_c = s9_tc_r; cc_c = s9_tb_r; end
      SC_N3:   begin ca_c = s9_ta_r; cb_c = s9_tb_r; cc_c = s9_tc_r; end
      SC_N4:   begin ca_c = s9_tc_r; cb_c = s9_tb_r; cc_c = s9_ta_r; end
      SC_N5:   begin ca_c = s9_tc_r; cb_c = s9_ta_r; cc_c = s9_tb_r; end
      SC_N6:   begin ca_c = s9_tb_r; cb_c = s9_tc_r; cc_c = s9_ta_r; end
      default: begin ca_c = s9_ta_r; cb_c = s9_ta_r; cc_c = s9_ta_r; end
    endcase
  end

  // ---- valid bits and payload ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIV_QW; i++) begin
        sd1_r[i].vld <= 1'b0;
        sd2_r[i].vld <= 1'b0;
      end
      s1_r.vld  <= 1'b0;
      s2_r.vld  <= 1'b0;
      s3_r.vld  <= 1'b0;
      s4_r.vld  <= 1'b0;
      s6_r.vld  <= 1'b0;
      s7_r.vld  <= 1'b0;
      s8_r.vld  <= 1'b0;
      s9_r.vld  <= 1'b0;
      res_r.vld <= 1'b0;
    end else begin
      sd1_r[0].vld <= sd1_in.vld;
      sd2_r[0].vld <= s4_r.vld;
      for (int i = 1; i < DIV_QW; i++) begin
        sd1_r[i].vld <= sd1_r[i-1].vld;
        sd2_r[i].vld <= sd2_r[i-1].vld;
      end
      s1_r.vld  <= sd1_r[DIV_QW-1].vld;
      s2_r.vld  <= s1_r.vld;
      s3_r.vld  <= s2_r.vld;
      s4_r.vld  <= s3_r.vld;
      s6_r.vld  <= sd2_r[DIV_QW-1].vld;
      s7_r.vld  <= s6_r.vld;
      s8_r.vld  <= s7_r.vld;
      s9_r.vld  <= s8_r.vld;
      res_r.vld <= s9_r.vld;
    end

    sd1_r[0].neg_x <= sd1_in.neg_x;
    sd1_r[0].neg_y <= sd1_in.neg_y;
    sd1_r[0].neg_z <= sd1_in.neg_z;
    sd1_r[0].per   <= sd1_in.per;
    sd1_r[0].code  <= sd1_in.code;
    sd1_r[0].uv    <= sd1_in.uv;
    for (int i = 1; i < DIV_QW; i++) begin
      sd1_r[i].neg_x <= sd1_r[i-1].neg_x;
      sd1_r[i].neg_y <= sd1_r[i-1].neg_y;
      sd1_r[i].neg_z <= sd1_r[i-1].neg_z;
      sd1_r[i].per   <= sd1_r[i-1].per;
      sd1_r[i].code  <= sd1_r[i-1].code;
      sd1_r[i].uv    <= sd1_r[i-1].uv;
    end

    // S1: signed X, Y, Z
    s1_r.neg_x <= sd1_r[DIV_QW-1].neg_x;
    s1_r.neg_y <= sd1_r[DIV_QW-1].neg_y;
    s1_r.neg_z <= sd1_r[DIV_QW-1].neg_z;
    s1_r.per   <= sd1_r[DIV_QW-1].per;
    s1_r.code  <= sd1_r[DIV_QW-1].code;
    s1_r.uv    <= sd1_r[DIV_QW-1].uv;
    s1_x_r     <= x_c;
    s1_y_r     <= y_c;
    s1_z_r     <= z_c;

    // S2: pick active times by sector
    s2_r.neg_x <= s1_r.neg_x;
    s2_r.neg_y <= s1_r.neg_y;
    s2_r.neg_z <= s1_r.neg_z;
    s2_r.per   <= s1_r.per;
    s2_r.code  <= s1_r.code;
    s2_r.uv    <= s1_r.uv;
    s2_tx_r    <= tx_c;
    s2_ty_r    <= ty_c;

    // S3: overmodulation test and magnitudes
    s3_r.neg_x <= s2_r.neg_x;
    s3_r.neg_y <= s2_r.neg_y;
    s3_r.neg_z <= s2_r.neg_z;
    s3_r.per   <= s2_r.per;
    s3_r.code  <= s2_r.code;
    s3_r.uv    <= s2_r.uv;
    s3_tx_r    <= s2_tx_r;
    s3_ty_r    <= s2_ty_r;
    s3_atx_r   <= s2_tx_r[TW-1] ? TW'(-s2_tx_r) : TW'(s2_tx_r);
    s3_aty_r   <= s2_ty_r[TW-1] ? TW'(-s2_ty_r) : TW'(s2_ty_r);
    s3_sum_r   <= SW'(sum_c);
    s3_ovm_r   <= (sum_c > pq_c);

    // S4: P * |T|
    s4_r.tx   <= s3_tx_r;
    s4_r.ty   <= s3_ty_r;
    s4_r.ntx  <= s3_tx_r[TW-1];
    s4_r.nty  <= s3_ty_r[TW-1];
    s4_r.ovm  <= s3_ovm_r;
    s4_r.per  <= s3_r.per;
    s4_r.code <= s3_r.code;
    s4_r.uv   <= s3_r.uv;
    s4_px_r   <= PRW'(s3_r.per) * PRW'(s3_atx_r);
    s4_py_r   <= PRW'(s3_r.per) * PRW'(s3_aty_r);
    s4_sum_r  <= s3_sum_r;

    sd2_r[0].tx   <= s4_r.tx;
    sd2_r[0].ty   <= s4_r.ty;
    sd2_r[0].ntx  <= s4_r.ntx;
    sd2_r[0].nty  <= s4_r.nty;
    sd2_r[0].ovm  <= s4_r.ovm;
    sd2_r[0].per  <= s4_r.per;
    sd2_r[0].code <= s4_r.code;
    sd2_r[0].uv   <= s4_r.uv;
    for (int i = 1; i < DIV_QW; i++) begin
      sd2_r[i].tx   <= sd2_r[i-1].tx;
      sd2_r[i].ty   <= sd2_r[i-1].ty;
      sd2_r[i].ntx  <= sd2_r[i-1].ntx;
      sd2_r[i].nty  <= sd2_r[i-1].nty;
      sd2_r[i].ovm  <= sd2_r[i-1].ovm;
      sd2_r[i].per  <= sd2_r[i-1].per;
      sd2_r[i].code <= sd2_r[i-1].code;
      sd2_r[i].uv   <= sd2_r[i-1].uv;
    end

    // S6: take rescaled times when overmodulated
    s6_r.tx   <= sd2_r[DIV_QW-1].tx;
    s6_r.ty   <= sd2_r[DIV_QW-1].ty;
    s6_r.ntx  <= sd2_r[DIV_QW-1].ntx;
    s6_r.nty  <= sd2_r[DIV_QW-1].nty;
    s6_r.ovm  <= sd2_r[DIV_QW-1].ovm;
    s6_r.per  <= sd2_r[DIV_QW-1].per;
    s6_r.code <= sd2_r[DIV_QW-1].code;
    s6_r.uv   <= sd2_r[DIV_QW-1].uv;
    s6_tx_r   <= sd2_r[DIV_QW-1].ovm ? rtx_c : sd2_r[DIV_QW-1].tx;
    s6_ty_r   <= sd2_r[DIV_QW-1].ovm ? rty_c : sd2_r[DIV_QW-1].ty;

    // S7: zero time span and half terms
    s7_r.tx   <= s6_r.tx;
    s7_r.ty   <= s6_r.ty;
    s7_r.ntx  <= s6_r.ntx;
    s7_r.nty  <= s6_r.nty;
    s7_r.ovm  <= s6_r.ovm;
    s7_r.per  <= s6_r.per;
    s7_r.code <= s6_r.code;
    s7_r.uv   <= s6_r.uv;
    s7_d_r    <= WW'({s6_r.per, 8'b0}) - tx_w - ty_w;
    s7_hx_r   <= tx_adj >>> 1;
    s7_hy_r   <= ty_adj >>> 1;

    // S8: Ta, Tb
    s8_r.tx   <= s7_r.tx;
    s8_r.ty   <= s7_r.ty;
    s8_r.ntx  <= s7_r.ntx;
    s8_r.nty  <= s7_r.nty;
    s8_r.ovm  <= s7_r.ovm;
    s8_r.per  <= s7_r.per;
    s8_r.code <= s7_r.code;
    s8_r.uv   <= s7_r.uv;
    s8_ta_r   <= ta_c;
    s8_tb_r   <= ta_c + s7_hx_r;
    s8_hy_r   <= s7_hy_r;

    // S9: Tc
    s9_r.tx   <= s8_r.tx;
    s9_r.ty   <= s8_r.ty;
    s9_r.ntx  <= s8_r.ntx;
    s9_r.nty  <= s8_r.nty;
    s9_r.ovm  <= s8_r.ovm;
    s9_r.per  <= s8_r.per;
    s9_r.code <= s8_r.code;
    s9_r.uv   <= s8_r.uv;
    s9_ta_r   <= s8_ta_r;
    s9_tb_r   <= s8_tb_r;
    s9_tc_r   <= s8_tb_r + s8_hy_r;

    // output register
    if (s9_r.uv) begin
      res_r.cmp_a  <= '0;
      res_r.cmp_b  <= '0;
      res_r.cmp_c  <= '0;
      res_r.sector <= '0;
      res_r.uv     <= 1'b1;
      res_r.ovm    <= 1'b0;
    end else begin
      res_r.cmp_a  <= to_cmp(ca_c, s9_r.per);
      res_r.cmp_b  <= to_cmp(cb_c, s9_r.per);
      res_r.cmp_c  <= to_cmp(cc_c, s9_r.per);
      res_r.sector <= sector_num(s9_r.code);
      res_r.uv     <= 1'b0;
      res_r.ovm    <= s9_r.ovm;
    end
  end

  assign res = res_r;

  a_uv_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (res_r.vld && res_r.uv) |->
      (res_r.cmp_a == '0 && res_r.cmp_b == '0 && res_r.cmp_c == '0 &&
       res_r.sector == '0 && !res_r.ovm))
    else $error("svpwm_back: undervoltage result not cleared");

  a_ovm_sector: assert property (@(posedge clk) disable iff (!rst_n)
    (res_r.vld && res_r.ovm) |-> (res_r.sector != '0))
    else $error("svpwm_back: rescale flagged on a degenerate vector");

  a_zero_vec: assert property (@(posedge clk) disable iff (!rst_n)
    (s9_r.vld && !s9_r.uv && (s9_r.code == SC_NONE_LO || s9_r.code == SC_NONE_HI))
      |=> (res_r.cmp_a == res_r.cmp_b && res_r.cmp_b == res_r.cmp_c))
    else $error("svpwm_back: degenerate vector gave unequal compares");

endmodule

### sv/space_vector_pwm_timing.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// space_vector_pwm_timing: space vector PWM compare generator
// Vector (alpha, beta) plus bus voltage in, three centered compares and the
// sector out, with undervoltage and overmodulation flags.
// ---------------------------------------------------------------------------
//
//  channel   handshake                 payload
//  -------   -----------------------   ----------------------------------------
//  input     start / busy              in_v_alpha, in_v_beta, in_bus_voltage
//  result    out_strobe (no stall)     out_compare_a/b/c, out_sector,
//                                      out_undervoltage, out_overmodulated
//  config    cfg_wr_en                 cfg_wr_data (pwm_period)
//
// One beat per cycle sustained; results come out in the order their beats were
// taken. The path runs through two banks of 34-stage pipelined dividers (dwell
// terms, then rescale) plus the front, the queue and the finishing stages.
// rst_n is synchronous; pwm_period resets to 16800 and all valids clear.
// busy rises only when the queue could not take everything already in flight;
// since the receiver cannot stall, the back drains every cycle and busy stays
// low in normal operation.
// ---------------------------------------------------------------------------
module space_vector_pwm_timing (
  input  logic                          clk,
  input  logic                          rst_n,
  // input beats
  input  logic                          start,
  output logic                          busy,
  input  logic signed [15:0]            in_v_alpha,
  input  logic signed [15:0]            in_v_beta,
  input  logic [15:0]                   in_bus_voltage,
  // configuration
  input  logic                          cfg_wr_en,
  input  logic [15:0]                   cfg_wr_data,
  // results
  output logic                          out_strobe,
  output logic [15:0]                   out_compare_a,
  output logic [15:0]                   out_compare_b,
  output logic [15:0]                   out_compare_c,
  output logic [2:0]                    out_sector,
  output logic                          out_undervoltage,
  output logic                          out_overmodulated
);
  import svpwm_pkg::*;

  // period register; only the low PW bits are kept
  logic [PW-1:0] per_r, per_nxt;

  always_comb begin
    per_nxt = per_r;
    if (cfg_wr_en) begin
      per_nxt = cfg_wr_data[PW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      per_r <= PERIOD_RST;
    end else begin
      per_r <= per_nxt;
    end
  end

  // front -> queue -> back
  q_stat_t  q_stat;
  logic     push;
  q_entry_t push_data;
  logic     rd_vld;
  q_entry_t rd_data;
  res_t     res;

  // sector classification and scaled numerators
  svpwm_front u_front (
    .clk,
    .rst_n,
    .start,
    .busy,
    .v_alpha     (in_v_alpha),
    .v_beta      (in_v_beta),
    .bus_voltage (in_bus_voltage),
    .period      (per_r),
    .q_stat,
    .push,
    .push_data
  );

  // decouples the front's credit loop from the back's pipeline
  svpwm_fifo u_fifo (
    .clk,
    .rst_n,
    .push,
    .push_data,
    .q_stat,
    .rd_vld,
    .rd_data
  );

  // divisions, sector pick, rescale and compare mapping
  svpwm_back u_back (
    .clk,
    .rst_n,
    .in_vld  (rd_vld),
    .in_data (rd_data),
    .res
  );

  assign out_strobe        = res.vld;
  assign out_compare_a     = res.cmp_a;
  assign out_compare_b     = res.cmp_b;
  assign out_compare_c     = res.cmp_c;
  assign out_sector        = res.sector;
  assign out_undervoltage  = res.uv;
  assign out_overmodulated = res.ovm;

endmodule
